>>> design/page_replacement_fifo_lru_top_assert.svh
// ---------------------------------------------------------------------------
// page replacement assertion macros
// shared property shapes, clocked on clk and disabled during reset
// ---------------------------------------------------------------------------
`ifndef PAGE_REPLACEMENT_FIFO_LRU_TOP_ASSERT_SVH
`define PAGE_REPLACEMENT_FIFO_LRU_TOP_ASSERT_SVH

// condition holds in the same cycle as the trigger
`define PRF_ASSERT_SAME(label, trig, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
        else $error(msg);

// condition holds in the cycle after the trigger
`define PRF_ASSERT_NEXT(label, trig, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error(msg);

`endif

>>> design/prf_pkg.sv
// ---------------------------------------------------------------------------
// prf_pkg
// shared types and constants of the page replacement unit
// ---------------------------------------------------------------------------
package prf_pkg;

    // configuration register indexes
    localparam logic CFG_POLICY = 1'b0;
    localparam logic CFG_FRAMES = 1'b1;

    // policy codes
    localparam logic POLICY_FIFO = 1'b0;
    localparam logic POLICY_LRU  = 1'b1;

    localparam int CFG_W       = 4;
    localparam int IN_PAGE_W   = 8;
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_SLOT_W  = 3;
    localparam int FAULT_W     = 16;
    localparam int OUT_TDATA_W = 32;

    localparam logic [FAULT_W-1:0] FAULT_MAX = {FAULT_W{1'b1}};
    localparam logic [CFG_W-1:0]   FRAMES_RESET = 4'd8;

    // lookup outcome from the frame table
    typedef struct packed {
        logic hit;
        logic evict;
    } prf_status_t;

endpackage

>>> design/prf_frames.sv
// ---------------------------------------------------------------------------
// prf_frames
// frame table: parallel page search, victim choice and recency ranks
// ---------------------------------------------------------------------------
module prf_frames
    import prf_pkg::*;
#(
    parameter int NUM_FRAMES = 8,
    parameter int PAGE_BITS  = 8,
    localparam int SLOT_W    = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 policy_mode,
    input  logic [CFG_W-1:0]     frame_count,
    input  logic [PAGE_BITS-1:0] page,
    input  logic                 update,
    output prf_status_t          status,
    output logic [SLOT_W-1:0]    slot,
    output logic [PAGE_BITS-1:0] evicted_page
);

    localparam int N_W = ($clog2(NUM_FRAMES + 1) > CFG_W) ? $clog2(NUM_FRAMES + 1) : CFG_W;

    logic [PAGE_BITS-1:0] pages_reg [NUM_FRAMES];
    logic [NUM_FRAMES-1:0] valid_reg;
    logic [NUM_FRAMES-1:0] valid_next;
    logic [SLOT_W-1:0]    rank_reg  [NUM_FRAMES];
    logic [SLOT_W-1:0]    rank_next [NUM_FRAMES];
    logic [SLOT_W-1:0]    hand_reg;
    logic [SLOT_W-1:0]    hand_next;

    logic [N_W-1:0]        n_active;
    logic [N_W-1:0]        fc_ext;
    logic [NUM_FRAMES-1:0] in_use;
    logic                  hit_found;
    logic [SLOT_W-1:0]     hit_slot;
    logic                  empty_found;
    logic [SLOT_W-1:0]     empty_slot;
    logic [SLOT_W-1:0]     lru_slot;
    logic [SLOT_W-1:0]     lru_best;
    logic [SLOT_W-1:0]     fifo_slot;
    logic [SLOT_W-1:0]     sel_slot;
    logic [N_W-1:0]        old_rank;
    logic [N_W-1:0]        slot_inc;

    // effective frame count, clamped to 1 .. NUM_FRAMES
    assign fc_ext = N_W'(frame_count);
    always_comb
    begin
        if (fc_ext == '0)
            n_active = N_W'(1);
        else if (fc_ext > N_W'(NUM_FRAMES))
            n_active = N_W'(NUM_FRAMES);
        else
            n_active = fc_ext;
    end

    always_comb
    begin
        for (int i = 0; i < NUM_FRAMES; i++)
            in_use[i] = N_W'(i) < n_active;
    end

    // lowest matching frame and lowest empty frame
    always_comb
    begin
        hit_found   = 1'b0;
        hit_slot    = '0;
        empty_found = 1'b0;
        empty_slot  = '0;
        for (int i = NUM_FRAMES - 1; i >= 0; i--)
        begin
            if (in_use[i] && valid_reg[i] && pages_reg[i] == page)
            begin
                hit_found = 1'b1;
                hit_slot  = SLOT_W'(i);
            end
            if (in_use[i] && !valid_reg[i])
            begin
                empty_found = 1'b1;
                empty_slot  = SLOT_W'(i);
            end
        end
    end

    // oldest rank, lowest slot on ties
    always_comb
    begin
        lru_best = rank_reg[0];
        lru_slot = '0;
        for (int i = 1; i < NUM_FRAMES; i++)
        begin
            if (in_use[i] && rank_reg[i] > lru_best)
            begin
                lru_best = rank_reg[i];
                lru_slot = SLOT_W'(i);
            end
        end
    end

    assign fifo_slot = (N_W'(hand_reg) < n_active) ? hand_reg : '0;

    always_comb
    begin
        priority if (hit_found)
            sel_slot = hit_slot;
        else if (empty_found)
            sel_slot = empty_slot;
        else if (policy_mode == POLICY_LRU)
            sel_slot = lru_slot;
        else
            sel_slot = fifo_slot;
    end

    assign status.hit   = hit_found;
    assign status.evict = !hit_found && !empty_found;
    assign slot         = sel_slot;
    assign evicted_page = status.evict ? pages_reg[sel_slot] : '0;

    // a freshly filled frame ages every valid frame in use
    assign old_rank = (hit_found || !empty_found) ? N_W'(rank_reg[sel_slot])
                                                  : N_W'(NUM_FRAMES);
    assign slot_inc = N_W'(sel_slot) + N_W'(1);

    always_comb
    begin
        for (int i = 0; i < NUM_FRAMES; i++)
        begin
            rank_next[i] = rank_reg[i];
            if (SLOT_W'(i) == sel_slot)
                rank_next[i] = '0;
            else if (in_use[i] && valid_reg[i] && N_W'(rank_reg[i]) < old_rank
                     && N_W'(rank_reg[i]) < N_W'(NUM_FRAMES - 1))
                rank_next[i] = rank_reg[i] + SLOT_W'(1);
        end
        valid_next = valid_reg;
        hand_next  = hand_reg;
        if (!hit_found)
        begin
            valid_next[sel_slot] = 1'b1;
            if (policy_mode == POLICY_FIFO)
                hand_next = (slot_inc < n_active) ? SLOT_W'(slot_inc) : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            hand_reg  <= '0;
            for (int i = 0; i < NUM_FRAMES; i++)
                rank_reg[i] <= '0;
        end
        else if (update)
        begin
            valid_reg <= valid_next;
            hand_reg  <= hand_next;
            rank_reg  <= rank_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (update && !hit_found)
            pages_reg[sel_slot] <= page;
    end

endmodule

>>> design/page_replacement_fifo_lru_top.sv
// ---------------------------------------------------------------------------
// page_replacement_fifo_lru_top
// page replacement unit with FIFO rotating hand or LRU victim choice
// ---------------------------------------------------------------------------
//  channel | direction | fields (low bit first)
//  s_*     | in        | tdata: page_number[7:0]
//  m_*     | out       | tdata: hit, frame_slot[2:0], evicted_valid,
//          |           |        evicted_page[7:0], fault_total[15:0], zero pad
//  cfg_*   | in        | addr 0 policy_mode, addr 1 frame_count
//
//  one reference per cycle while the result register is not stalled; a beat
//  sits in the input register, where the frame search and victim choice run,
//  then in the result register until taken
//  a stalled result register holds the input register, which then drops s_tready
//  reset empties all frames, clears ranks, hand and fault count
// ---------------------------------------------------------------------------
module page_replacement_fifo_lru_top
    import prf_pkg::*;
#(
    parameter int NUM_FRAMES = 8,
    parameter int PAGE_BITS  = 8
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,   // page_number
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,   // hit, frame_slot, evicted_valid,
                                              // evicted_page, fault_total
    input  logic                   cfg_we,
    input  logic                   cfg_addr,
    input  logic [CFG_W-1:0]       cfg_wdata
);

    localparam int SLOT_W = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
    localparam int PAYLOAD_W = 1 + OUT_SLOT_W + 1 + IN_PAGE_W + FAULT_W;

    logic                   policy_reg;
    logic [CFG_W-1:0]       frames_reg;
    logic                   in_valid_reg;
    logic [PAGE_BITS-1:0]   page_reg;
    logic                   out_valid_reg;
    logic [OUT_TDATA_W-1:0] out_data_reg;
    logic [OUT_TDATA_W-1:0] out_data_next;
    logic [FAULT_W-1:0]     fault_cnt_reg;
    logic [FAULT_W-1:0]     fault_cnt_next;
    logic                   advance;
    prf_status_t            stat;
    logic [SLOT_W-1:0]      slot;
    logic [PAGE_BITS-1:0]   evicted_page;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            policy_reg <= POLICY_FIFO;
            frames_reg <= FRAMES_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                CFG_POLICY: policy_reg <= cfg_wdata[0];
                CFG_FRAMES: frames_reg <= cfg_wdata;
                default:    frames_reg <= frames_reg;
            endcase
        end
    end

    prf_frames #(
        .NUM_FRAMES (NUM_FRAMES),
        .PAGE_BITS  (PAGE_BITS)
    ) u_frames (
        .clk          (clk),
        .rst_n        (rst_n),
        .policy_mode  (policy_reg),
        .frame_count  (frames_reg),
        .page         (page_reg),
        .update       (advance),
        .status       (stat),
        .slot         (slot),
        .evicted_page (evicted_page)
    );

    // saturating fault count
    assign fault_cnt_next = (!stat.hit && fault_cnt_reg != FAULT_MAX)
                            ? fault_cnt_reg + FAULT_W'(1) : fault_cnt_reg;

    assign out_data_next = {
        (OUT_TDATA_W - PAYLOAD_W)'(0),
        fault_cnt_next,
        IN_PAGE_W'(evicted_page),
        stat.evict,
        OUT_SLOT_W'(slot),
        stat.hit
    };

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            fault_cnt_reg <= '0;
        end
        else
        begin
            if (s_tready)
                in_valid_reg <= s_tvalid;
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                fault_cnt_reg <= fault_cnt_next;
            end
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
            page_reg <= PAGE_BITS'(s_tdata);
        if (advance)
            out_data_reg <= out_data_next;
    end

`include "page_replacement_fifo_lru_top_assert.svh"

    `PRF_ASSERT_NEXT(a_fault_monotonic, 1'b1, fault_cnt_reg >= $past(fault_cnt_reg), "fault count went down")
    `PRF_ASSERT_NEXT(a_hit_keeps_count, advance && stat.hit, $stable(fault_cnt_reg), "fault count moved on a hit")
    `PRF_ASSERT_SAME(a_hit_no_evict, advance && stat.hit, !stat.evict, "hit reported with eviction")
    `PRF_ASSERT_NEXT(a_stall_holds_input, in_valid_reg && !advance, in_valid_reg && $stable(page_reg), "input register lost a stalled beat")
    `PRF_ASSERT_SAME(a_evict_page_zero, out_valid_reg && !out_data_reg[1 + OUT_SLOT_W], out_data_reg[1 + OUT_SLOT_W + IN_PAGE_W:2 + OUT_SLOT_W] == '0, "evicted page set without eviction")

endmodule
